### hw/rtl/spr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spr_pkg
// Shared types and constants of the stereo polyphase resampler.
// ----------------------------------------------------------------------------
package spr_pkg;

   // item kinds carried on req_tuser
   localparam logic MODE_COEF  = 1'b0;
   localparam logic MODE_FRAME = 1'b1;

   // register indexes (byte address = 8 * index)
   localparam logic [2:0] REG_STEP        = 3'd0;
   localparam logic [2:0] REG_TAP_BLOCKS  = 3'd1;
   localparam logic [2:0] REG_PHASE_BITS  = 3'd2;
   localparam logic [2:0] REG_LCG_MULT    = 3'd3;
   localparam logic [2:0] REG_LCG_ADD     = 3'd4;
   localparam logic [2:0] REG_DITHER_SEED = 3'd5;
   localparam logic [2:0] REG_START_POS   = 3'd6;

   // register reset values
   localparam logic [40:0] RST_STEP        = 41'h100000000;
   localparam logic [2:0]  RST_TAP_BLOCKS  = 3'd1;
   localparam logic [2:0]  RST_PHASE_BITS  = 3'd5;
   localparam logic [31:0] RST_LCG_MULT    = 32'd1103515245;
   localparam logic [31:0] RST_LCG_ADD     = 32'd12345;
   localparam logic [31:0] RST_DITHER_SEED = 32'd0;
   localparam logic [41:0] RST_START_POS   = 42'd0;

   localparam int unsigned MAX_RESULTS = 64;

   typedef struct packed {
      logic [40:0] step;
      logic [2:0]  tap_blocks;
      logic [2:0]  phase_bits;
      logic [31:0] lcg_mult;
      logic [31:0] lcg_add;
   } cfg_type;

   // one-cycle seed loads toward the engine
   typedef struct packed {
      logic        pos_load;
      logic [41:0] pos_value;
      logic        dith_load;
      logic [31:0] dith_value;
   } load_type;

   typedef struct packed {
      logic        mode;
      logic        idx_ok;
      logic [10:0] coeff_index;
      logic [15:0] coeff_value;
      logic [15:0] left_in;
      logic [15:0] right_in;
   } item_type;

endpackage

### hw/rtl/stereo_polyphase_resampler_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stereo_polyphase_resampler_top
// Stereo polyphase sample-rate converter with interpolated coefficients.
//
//   channel   dir  handshake         contents
//   req_*     in   tvalid/tready     coefficient write or stereo frame
//   rsp_*     out  tvalid/tready     resampled stereo word, tlast ends a frame
//   csr_*     in   APB-style         configuration registers, 8-byte spaced
//
// Per output, a frame runs through check, slot setup, the taps in turn through
// the shared multiply-accumulate, pipeline drain, dither of each channel and store.
// Reset is synchronous; control clears at once, the coefficient bank does not.
// A two-word queue lets the input side run on while the engine stalls on rsp.
// ----------------------------------------------------------------------------
module stereo_polyphase_resampler_top #(
   parameter int unsigned MAX_TAPS           = 32,
   parameter int unsigned LOG2_PHASES        = 5,
   parameter int unsigned INTERP_WEIGHT_BITS = 14
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,  // coeff_index, coeff_value, left_in, right_in
   input  logic        req_tuser,  // mode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,  // left_out, right_out
   output logic        rsp_tlast,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [5:0]  csr_paddr,
   input  logic [63:0] csr_pwdata,
   output logic [63:0] csr_prdata,
   output logic        csr_pready
);

   localparam int unsigned DEPTH = ((1 << LOG2_PHASES) + 1) * MAX_TAPS;

   spr_pkg::cfg_type  cfg;
   spr_pkg::load_type load;
   spr_pkg::item_type q_item;
   logic              q_valid;
   logic              q_pop;

   spr_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg),
      .load        (load)
   );

   spr_front #(.BANK_DEPTH(DEPTH)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop)
   );

   spr_engine #(
      .MAX_TAPS           (MAX_TAPS),
      .LOG2_PHASES        (LOG2_PHASES),
      .INTERP_WEIGHT_BITS (INTERP_WEIGHT_BITS)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .load       (load),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

### hw/rtl/spr_csr.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spr_csr
// Configuration registers behind an APB-style port; issues seed loads.
// ----------------------------------------------------------------------------
module spr_csr (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [5:0]        csr_paddr,
   input  logic [63:0]       csr_pwdata,
   output logic [63:0]       csr_prdata,
   output logic              csr_pready,
   output spr_pkg::cfg_type  cfg,
   output spr_pkg::load_type load
);

   logic [40:0] step_ff;
   logic [2:0]  blocks_ff;
   logic [2:0]  pbits_ff;
   logic [31:0] mult_ff;
   logic [31:0] add_ff;
   logic [31:0] seed_ff;
   logic [41:0] start_ff;
   logic [2:0]  idx;
   logic        wr;

   assign idx        = csr_paddr[5:3];
   assign wr         = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff   <= spr_pkg::RST_STEP;
         blocks_ff <= spr_pkg::RST_TAP_BLOCKS;
         pbits_ff  <= spr_pkg::RST_PHASE_BITS;
         mult_ff   <= spr_pkg::RST_LCG_MULT;
         add_ff    <= spr_pkg::RST_LCG_ADD;
         seed_ff   <= spr_pkg::RST_DITHER_SEED;
         start_ff  <= spr_pkg::RST_START_POS;
      end else if (wr) begin
         unique case (idx)
            spr_pkg::REG_STEP:        step_ff   <= csr_pwdata[40:0];
            spr_pkg::REG_TAP_BLOCKS:  blocks_ff <= csr_pwdata[2:0];
            spr_pkg::REG_PHASE_BITS:  pbits_ff  <= csr_pwdata[2:0];
            spr_pkg::REG_LCG_MULT:    mult_ff   <= csr_pwdata[31:0];
            spr_pkg::REG_LCG_ADD:     add_ff    <= csr_pwdata[31:0];
            spr_pkg::REG_DITHER_SEED: seed_ff   <= csr_pwdata[31:0];
            spr_pkg::REG_START_POS:   start_ff  <= csr_pwdata[41:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         spr_pkg::REG_STEP:        csr_prdata = {23'd0, step_ff};
         spr_pkg::REG_TAP_BLOCKS:  csr_prdata = {61'd0, blocks_ff};
         spr_pkg::REG_PHASE_BITS:  csr_prdata = {61'd0, pbits_ff};
         spr_pkg::REG_LCG_MULT:    csr_prdata = {32'd0, mult_ff};
         spr_pkg::REG_LCG_ADD:     csr_prdata = {32'd0, add_ff};
         spr_pkg::REG_DITHER_SEED: csr_prdata = {32'd0, seed_ff};
         spr_pkg::REG_START_POS:   csr_prdata = {{22{start_ff[41]}}, start_ff};
         default:                  csr_prdata = 64'd0;
      endcase
   end

   assign cfg.step       = step_ff;
   assign cfg.tap_blocks = blocks_ff;
   assign cfg.phase_bits = pbits_ff;
   assign cfg.lcg_mult   = mult_ff;
   assign cfg.lcg_add    = add_ff;

   assign load.pos_load   = wr && (idx == spr_pkg::REG_START_POS);
   assign load.pos_value  = csr_pwdata[41:0];
   assign load.dith_load  = wr && (idx == spr_pkg::REG_DITHER_SEED);
   assign load.dith_value = csr_pwdata[31:0];

endmodule

### hw/rtl/spr_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spr_front
// Accepts input words, classifies them and queues them for the engine.
// ----------------------------------------------------------------------------
module spr_front #(
   parameter int unsigned BANK_DEPTH = 1056
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [63:0]       req_tdata,
   input  logic              req_tuser,
   output logic              q_valid,
   output spr_pkg::item_type q_item,
   input  logic              q_pop
);

   spr_pkg::item_type ent_ff [2];
   logic       wp_ff;
   logic       rp_ff;
   logic [1:0] cnt_ff;
   logic       push;
   spr_pkg::item_type item_in;

   always_comb begin
      item_in.mode        = req_tuser;
      item_in.coeff_index = req_tdata[10:0];
      item_in.coeff_value = req_tdata[26:11];
      item_in.left_in     = req_tdata[42:27];
      item_in.right_in    = req_tdata[58:43];
      // flag writes that fall outside the bank; they are dropped later
      item_in.idx_ok      = 32'(req_tdata[10:0]) < 32'(BANK_DEPTH);
   end

   assign req_tready = cnt_ff != 2'd2;
   assign push       = req_tvalid & req_tready;
   assign q_valid    = cnt_ff != 2'd0;
   assign q_item     = ent_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wp_ff] <= item_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) wp_ff <= ~wp_ff;
         if (q_pop) rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + 2'(push) - 2'(q_pop);
      end
   end

endmodule

### hw/rtl/spr_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spr_engine
// Coefficient bank, history ring and the shared multiply-accumulate that
// computes each output, with dither, saturation and the output register.
// ----------------------------------------------------------------------------
module spr_engine #(
   parameter int unsigned MAX_TAPS           = 32,
   parameter int unsigned LOG2_PHASES        = 5,
   parameter int unsigned INTERP_WEIGHT_BITS = 14
) (
   input  logic              clock,
   input  logic              reset,
   input  spr_pkg::cfg_type  cfg,
   input  spr_pkg::load_type load,
   input  logic              q_valid,
   input  spr_pkg::item_type q_item,
   output logic              q_pop,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [31:0]       rsp_tdata,
   output logic              rsp_tlast
);

   localparam int unsigned W       = INTERP_WEIGHT_BITS;
   localparam int unsigned DEPTH   = ((1 << LOG2_PHASES) + 1) * MAX_TAPS;
   localparam int unsigned ADDR_W  = $clog2(DEPTH);
   localparam int unsigned SLOT_W  = $clog2(MAX_TAPS);
   localparam int unsigned TAP_W   = $clog2(MAX_TAPS + 1);
   localparam int unsigned FN_W    = LOG2_PHASES + 1;
   localparam int unsigned PW      = 16 + W + 2;
   localparam int unsigned BMAX    = MAX_TAPS / 8;
   localparam int unsigned WONE    = 1 << W;

   typedef enum logic [2:0] {
      ST_IDLE, ST_CHECK, ST_REM, ST_TAPS, ST_DRAIN, ST_DITH_L, ST_DITH_R, ST_STORE
   } state_type;

   function automatic logic [15:0] sat15(input logic [31:0] a);
      logic signed [31:0] sh;
      logic signed [16:0] v;
      sh = $signed(a) >>> 15;
      v  = sh[16:0];
      if (v > 17'sd32767)       sat15 = 16'h7fff;
      else if (v < -17'sd32768) sat15 = 16'h8000;
      else                      sat15 = v[15:0];
   endfunction

   state_type           state_ff;
   logic [63:0]         pos_ff;
   logic [47:0]         fs_ff;
   logic [31:0]         ds_ff;
   logic [SLOT_W-1:0]   wslot_ff;
   logic [MAX_TAPS-1:0] hvalid_ff;
   logic [6:0]          cnt_ff;
   logic                pend_ff;
   logic [15:0]         pl_ff;
   logic [15:0]         pr_ff;
   logic [FN_W-1:0]     fn_ff;
   logic [W-1:0]        ff1_ff;
   logic [ADDR_W-1:0]   base0_ff;
   logic [ADDR_W-1:0]   base1_ff;
   logic [SLOT_W-1:0]   t_ff;
   logic [SLOT_W-1:0]   slot_ff;
   logic [31:0]         accl_ff;
   logic [31:0]         accr_ff;
   logic                out_vld_ff;
   logic [31:0]         out_data_ff;
   logic                out_last_ff;

   // tap pipeline: s1 memory read, s2 blend products, s3 blended coefficient,
   // s4 sample products, then accumulate
   logic                s1_ff, s2_ff, s3_ff, s4_ff;
   logic                k1_ff, k2_ff, k3_ff, k4_ff;
   logic [15:0]         c0_ff, c1_ff, hl_ff, hr_ff;
   logic signed [PW-1:0] p0_ff, p1_ff;
   logic [15:0]         hl2_ff, hr2_ff, hl3_ff, hr3_ff;
   logic [15:0]         f_ff;
   logic [31:0]         ml_ff, mr_ff;

   logic signed [15:0]  coef_bank [DEPTH];
   logic [15:0]         hist_l [MAX_TAPS];
   logic [15:0]         hist_r [MAX_TAPS];

   // combinational helpers
   logic [5:0]          blocks_c;
   logic [TAP_W-1:0]    ntaps;
   logic [3:0]          pb_c;
   logic [31:0]         off;
   logic [63:0]         frac_sh;
   logic signed [49:0]  emit_lhs;
   logic                due;
   logic                out_free;
   logic                push_out;
   logic [ADDR_W-1:0]   base0_in;
   logic [32:0]         k_tap;
   logic                issue;
   logic                coef_we;
   logic                hist_we;
   logic [ADDR_W-1:0]   ra0, ra1;
   logic [W:0]          ff0;
   logic signed [PW:0]  blend;
   logic [31:0]         ds_in;
   logic [63:0]         pos_in;

   always_comb begin
      blocks_c = {3'd0, cfg.tap_blocks};
      if (blocks_c == 6'd0) blocks_c = 6'd1;
      if (blocks_c > 6'(BMAX)) blocks_c = 6'(BMAX);
      ntaps = TAP_W'({blocks_c, 3'b000});
      pb_c  = {1'b0, cfg.phase_bits};
      if (pb_c > 4'(LOG2_PHASES)) pb_c = 4'(LOG2_PHASES);
   end

   assign off      = pos_ff[63:32];
   assign frac_sh  = {32'd0, pos_ff[31:0]} << pb_c;
   assign emit_lhs = $signed({{18{off[31]}}, off}) + $signed(50'(ntaps));
   assign due      = (emit_lhs <= $signed({2'b00, fs_ff})) &&
                     (cnt_ff < 7'(spr_pkg::MAX_RESULTS));
   assign out_free = !out_vld_ff || rsp_tready;
   assign push_out = (state_ff == ST_CHECK) && pend_ff && out_free;

   assign base0_in = ADDR_W'(fn_ff * ntaps);

   assign k_tap    = {off[31], off} + 33'(t_ff);
   assign issue    = state_ff == ST_TAPS;
   assign ra0      = base0_ff + ADDR_W'(t_ff);
   assign ra1      = base1_ff + ADDR_W'(t_ff);

   assign q_pop    = (state_ff == ST_IDLE) && q_valid;
   assign coef_we  = q_pop && (q_item.mode == spr_pkg::MODE_COEF) && q_item.idx_ok;
   assign hist_we  = q_pop && (q_item.mode == spr_pkg::MODE_FRAME);

   assign ff0      = (W+1)'(WONE) - {1'b0, ff1_ff};
   assign blend    = (PW+1)'(p0_ff) + (PW+1)'(p1_ff);

   assign ds_in    = 32'(ds_ff * cfg.lcg_mult) + cfg.lcg_add;
   assign pos_in   = pos_ff + {23'd0, cfg.step};

   // coefficient bank: one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (coef_we) begin
         coef_bank[ADDR_W'(q_item.coeff_index)] <= q_item.coeff_value;
      end
      c0_ff <= coef_bank[ra0];
      c1_ff <= coef_bank[ra1];
   end

   // history ring; entries not yet written read as zero
   always_ff @(posedge clock) begin
      if (hist_we) begin
         hist_l[wslot_ff] <= q_item.left_in;
         hist_r[wslot_ff] <= q_item.right_in;
      end
      hl_ff <= hvalid_ff[slot_ff] ? hist_l[slot_ff] : 16'd0;
      hr_ff <= hvalid_ff[slot_ff] ? hist_r[slot_ff] : 16'd0;
   end

   // datapath stages
   always_ff @(posedge clock) begin
      p0_ff  <= $signed(c0_ff) * $signed({1'b0, ff0});
      p1_ff  <= $signed(c1_ff) * $signed({1'b0, 1'b0, ff1_ff});
      hl2_ff <= hl_ff;
      hr2_ff <= hr_ff;
      f_ff   <= blend[W+15:W];
      hl3_ff <= hl2_ff;
      hr3_ff <= hr2_ff;
      ml_ff  <= 32'($signed(hl3_ff) * $signed(f_ff));
      mr_ff  <= 32'($signed(hr3_ff) * $signed(f_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         pos_ff      <= {{22{spr_pkg::RST_START_POS[41]}}, spr_pkg::RST_START_POS};
         fs_ff       <= 48'd0;
         ds_ff       <= spr_pkg::RST_DITHER_SEED;
         wslot_ff    <= '0;
         hvalid_ff   <= '0;
         cnt_ff      <= 7'd0;
         pend_ff     <= 1'b0;
         out_vld_ff  <= 1'b0;
         s1_ff       <= 1'b0;
         s2_ff       <= 1'b0;
         s3_ff       <= 1'b0;
         s4_ff       <= 1'b0;
      end else begin
         s1_ff <= issue;
         s2_ff <= s1_ff;
         s3_ff <= s2_ff;
         s4_ff <= s3_ff;
         k1_ff <= !k_tap[32];
         k2_ff <= k1_ff;
         k3_ff <= k2_ff;
         k4_ff <= k3_ff;
         if (s4_ff && k4_ff) begin
            accl_ff <= accl_ff + ml_ff;
            accr_ff <= accr_ff + mr_ff;
         end

         if (push_out) begin
            out_vld_ff  <= 1'b1;
            out_data_ff <= {pr_ff, pl_ff};
            out_last_ff <= !due;
         end else if (rsp_tready) begin
            out_vld_ff <= 1'b0;
         end

         if (load.pos_load) pos_ff <= {{22{load.pos_value[41]}}, load.pos_value};
         if (load.dith_load) ds_ff <= load.dith_value;

         unique case (state_ff)
            ST_IDLE: begin
               if (hist_we) begin
                  hvalid_ff[wslot_ff] <= 1'b1;
                  wslot_ff <= (wslot_ff == SLOT_W'(MAX_TAPS - 1)) ? '0 : wslot_ff + 1'b1;
                  fs_ff    <= fs_ff + 48'd1;
                  cnt_ff   <= 7'd0;
                  state_ff <= ST_CHECK;
               end
            end
            ST_CHECK: begin
               // hold until the previous output can leave
               if (!pend_ff || out_free) begin
                  pend_ff <= 1'b0;
                  if (due) begin
                     fn_ff    <= frac_sh[32 +: FN_W];
                     ff1_ff   <= frac_sh[31 -: W];
                     accl_ff  <= 32'd0;
                     accr_ff  <= 32'd0;
                     state_ff <= ST_REM;
                  end else begin
                     state_ff <= ST_IDLE;
                  end
               end
            end
            ST_REM: begin
               // MAX_TAPS is a power of two: the low bits of off give the ring slot
               base0_ff <= base0_in;
               base1_ff <= base0_in + ADDR_W'(ntaps);
               slot_ff  <= off[SLOT_W-1:0];
               t_ff     <= '0;
               state_ff <= ST_TAPS;
            end
            ST_TAPS: begin
               t_ff    <= t_ff + 1'b1;
               slot_ff <= (slot_ff == SLOT_W'(MAX_TAPS - 1)) ? '0 : slot_ff + 1'b1;
               if (TAP_W'(t_ff) == ntaps - 1'b1) state_ff <= ST_DRAIN;
            end
            ST_DRAIN: begin
               if (!s1_ff && !s2_ff && !s3_ff && !s4_ff) state_ff <= ST_DITH_L;
            end
            ST_DITH_L: begin
               accl_ff  <= accl_ff + {17'd0, ds_ff[31:17]};
               ds_ff    <= ds_in;
               state_ff <= ST_DITH_R;
            end
            ST_DITH_R: begin
               accr_ff  <= accr_ff + {17'd0, ds_ff[31:17]};
               ds_ff    <= ds_in;
               state_ff <= ST_STORE;
            end
            ST_STORE: begin
               pl_ff    <= sat15(accl_ff);
               pr_ff    <= sat15(accr_ff);
               pend_ff  <= 1'b1;
               pos_ff   <= pos_in;
               cnt_ff   <= cnt_ff + 7'd1;
               state_ff <= ST_CHECK;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

### hw/rtl/spr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spr_checker
// Port-level checks on the resampler, bound to the top level.
// ----------------------------------------------------------------------------
module spr_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic        rsp_tlast,
   input logic        csr_pready
);

   // stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("rsp word changed while stalled");

   a_pready: assert property (@(posedge clock) disable iff (reset) csr_pready)
      else $error("csr_pready dropped");

   // output register is empty right after reset
   a_rst_empty: assert property (@(posedge clock) $past(reset) |-> !rsp_tvalid)
      else $error("rsp_tvalid high after reset");

   // the input queue only fills on an accepted word
   a_ready_fall: assert property (@(posedge clock) disable iff (reset)
      $fell(req_tready) |-> $past(req_tvalid && req_tready))
      else $error("req_tready fell without an accept");

endmodule

bind stereo_polyphase_resampler_top spr_checker u_spr_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .csr_pready (csr_pready)
);

### tb/stereo_polyphase_resampler_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stereo_polyphase_resampler_top_test
// Self-checking bench for the stereo polyphase resampler. Coefficient writes
// and stereo frames go in on req_*, and a bit-true behavioral copy of the
// resampler (history rings, coefficient bank, 32.32 position, dither
// generator) predicts every rsp word. Registers are set over csr_* between
// phases, with both stream sides idling and stalling at random.
// ----------------------------------------------------------------------------
module stereo_polyphase_resampler_top_test;

   localparam int BANK_WORDS = 1056;
   // filled part of the bank; settings keep every phase in use inside it
   localparam int BANK_FILL = 264;
   localparam int WATCH_LIMIT = 20000;

   typedef struct {
      logic [15:0] left;
      logic [15:0] right;
      logic        last;
   } sample_pair_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [63:0] req_tdata;
   logic        req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [5:0]  csr_paddr;
   logic [63:0] csr_pwdata;
   logic [63:0] csr_prdata;
   logic        csr_pready;

   stereo_polyphase_resampler_top i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata), .csr_pready(csr_pready)
   );

   // resampler copy
   bit [40:0]   step_q;
   bit [2:0]    tap_blocks_q;
   bit [2:0]    phase_bits_q;
   bit [31:0]   lcg_mult_q;
   bit [31:0]   lcg_add_q;
   bit [63:0]   position_q;
   bit [47:0]   frames_q;
   bit [31:0]   dither_q;
   shortint     hist_left[32];
   shortint     hist_right[32];
   shortint     coeff_bank[BANK_WORDS];

   sample_pair_type pending_words[$];
   int  error_count;
   int  frames_sent;
   int  coeffs_sent;
   int  words_checked;
   int  idle_cycles;
   bit  gaps_on;
   bit  long_stall_request;
   int  rsp_hold;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [15:0] saturate_q15(bit [31:0] acc);
      longint v;
      v = longint'($signed(acc)) >>> 15;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v[15:0];
   endfunction

   function automatic void resample_frame(logic [15:0] l, logic [15:0] r);
      int unsigned blocks, ntaps, pb, fn, ff0, ff1, slot, cnt;
      longint off, k, c0, c1;
      int f;
      bit [31:0] frac, acc_l, acc_r;
      sample_pair_type w;
      hist_left[frames_q % 32] = l;
      hist_right[frames_q % 32] = r;
      frames_q = frames_q + 48'd1;
      blocks = tap_blocks_q;
      if (blocks < 1) blocks = 1;
      if (blocks > 4) blocks = 4;
      ntaps = blocks * 8;
      pb = (phase_bits_q > 5) ? 5 : phase_bits_q;
      cnt = 0;
      while (cnt < spr_pkg::MAX_RESULTS) begin
         off = longint'($signed(position_q[63:32]));
         frac = position_q[31:0];
         if (off + longint'(ntaps) > longint'(frames_q)) break;
         fn = (pb != 0) ? (frac >> (32 - pb)) : 0;
         ff1 = (frac >> (32 - pb - 14)) & 32'h3fff;
         ff0 = 16384 - ff1;
         acc_l = 0;
         acc_r = 0;
         for (int t = 0; t < ntaps; t++) begin
            c0 = coeff_bank[fn * ntaps + t];
            c1 = coeff_bank[(fn + 1) * ntaps + t];
            f = int'((c0 * longint'(ff0) + c1 * longint'(ff1)) >>> 14);
            k = off + t;
            if (k < 0) continue;
            slot = 32'(k % 32);
            acc_l += int'(hist_left[slot]) * f;
            acc_r += int'(hist_right[slot]) * f;
         end
         acc_l += dither_q >> 17;
         dither_q = dither_q * lcg_mult_q + lcg_add_q;
         acc_r += dither_q >> 17;
         dither_q = dither_q * lcg_mult_q + lcg_add_q;
         w.left = saturate_q15(acc_l);
         w.right = saturate_q15(acc_r);
         w.last = 1'b0;
         pending_words.push_back(w);
         position_q += {{23{1'b0}}, step_q};
         cnt++;
      end
      if (cnt > 0) pending_words[pending_words.size() - 1].last = 1'b1;
   endfunction

   task automatic csr_write(logic [2:0] idx, logic [63:0] value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 3'b000};
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      idle_cycles = 0;
      case (idx)
         spr_pkg::REG_STEP:        step_q = value[40:0];
         spr_pkg::REG_TAP_BLOCKS:  tap_blocks_q = value[2:0];
         spr_pkg::REG_PHASE_BITS:  phase_bits_q = value[2:0];
         spr_pkg::REG_LCG_MULT:    lcg_mult_q = value[31:0];
         spr_pkg::REG_LCG_ADD:     lcg_add_q = value[31:0];
         spr_pkg::REG_DITHER_SEED: dither_q = value[31:0];
         spr_pkg::REG_START_POS:   position_q = {{22{value[41]}}, value[41:0]};
         default: ;
      endcase
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic send_word(logic mode, logic [10:0] idx, logic [15:0] cv,
                            logic [15:0] l, logic [15:0] r);
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser <= mode;
      req_tdata <= {5'd0, r, l, cv, idx};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (mode == spr_pkg::MODE_FRAME) begin
         resample_frame(l, r);
         frames_sent++;
      end else begin
         if (idx < BANK_WORDS) coeff_bank[idx] = cv;
         coeffs_sent++;
      end
   endtask

   task automatic sender_gap();
      int n;
      n = 0;
      if (gaps_on) begin
         case ($urandom_range(0, 19))
            0:       n = $urandom_range(20, 150);
            1, 2, 3, 4, 5: n = $urandom_range(1, 3);
            default: n = 0;
         endcase
      end
      if (n > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (n - 1) @(negedge clock);
      end
   endtask

   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_words.size() != 0) @(posedge clock);
      // coefficient writes leave nothing to wait for; let the engine settle
      repeat (200) @(posedge clock);
   endtask

   function automatic logic [15:0] pick_sample();
      case ($urandom_range(0, 9))
         0: return 16'h7fff;
         1: return 16'h8000;
         2: return 16'h0000;
         default: return 16'($urandom());
      endcase
   endfunction

   task automatic run_random(int n);
      for (int i = 0; i < n; i++) begin
         sender_gap();
         if ($urandom_range(0, 99) < 15)
            send_word(spr_pkg::MODE_COEF, 11'($urandom_range(0, 2047)), pick_sample(),
                      16'h0, 16'h0);
         else
            send_word(spr_pkg::MODE_FRAME, 11'($urandom()), 16'($urandom()),
                      pick_sample(), pick_sample());
      end
   endtask

   task automatic test_bank_fill();
      gaps_on = 1'b0;
      for (int i = 0; i < BANK_FILL; i++)
         send_word(spr_pkg::MODE_COEF, 11'(i),
                   $urandom_range(0, 1) ? pick_sample() : 16'($urandom_range(0, 3000)),
                   16'($urandom()), 16'($urandom()));
      drain();
   endtask

   task automatic test_directed();
      gaps_on = 1'b1;
      send_word(spr_pkg::MODE_COEF, 11'd2047, 16'h7fff, 16'hffff, 16'hffff);
      send_word(spr_pkg::MODE_COEF, 11'd1056, 16'h8000, 16'h0, 16'h0);
      send_word(spr_pkg::MODE_COEF, 11'd0, 16'h7fff, 16'h0, 16'h0);
      send_word(spr_pkg::MODE_COEF, 11'd1, 16'h8000, 16'h0, 16'h0);
      send_word(spr_pkg::MODE_COEF, 11'd1055, 16'hffff, 16'h0, 16'h0);
      for (int i = 0; i < 12; i++)
         send_word(spr_pkg::MODE_FRAME, 11'h7ff, 16'hffff,
                   (i % 2) ? 16'h7fff : 16'h8000, (i % 2) ? 16'h8000 : 16'h7fff);
      send_word(spr_pkg::MODE_FRAME, 11'd0, 16'd0, 16'd0, 16'd0);
      send_word(spr_pkg::MODE_FRAME, 11'd0, 16'd0, 16'hffff, 16'h0001);
      drain();
   endtask

   // smallest step: every frame hits the output cap, history starts below zero
   task automatic test_output_cap();
      csr_write(spr_pkg::REG_STEP, 64'h4000000);
      csr_write(spr_pkg::REG_TAP_BLOCKS, 64'd7);
      csr_write(spr_pkg::REG_PHASE_BITS, 64'd2);
      csr_write(spr_pkg::REG_START_POS, -64'sh100_0000_0000);
      gaps_on = 1'b1;
      run_random(10);
      drain();
   endtask

   task automatic test_extreme_positions();
      csr_write(spr_pkg::REG_START_POS, 64'h100_0000_0000);
      gaps_on = 1'b1;
      run_random(6);
      drain();
      csr_write(spr_pkg::REG_STEP, 64'h100_0000_0000);
      csr_write(spr_pkg::REG_START_POS, 64'h200_0000_0000);
      csr_write(spr_pkg::REG_TAP_BLOCKS, 64'd0);
      csr_write(spr_pkg::REG_PHASE_BITS, 64'd0);
      run_random(6);
      drain();
   endtask

   task automatic test_dither_extremes();
      csr_write(spr_pkg::REG_STEP, 64'h1_0000_0000);
      csr_write(spr_pkg::REG_TAP_BLOCKS, 64'd0);
      csr_write(spr_pkg::REG_PHASE_BITS, 64'd7);
      csr_write(spr_pkg::REG_LCG_MULT, 64'hffff_ffff);
      csr_write(spr_pkg::REG_LCG_ADD, 64'hffff_ffff);
      csr_write(spr_pkg::REG_DITHER_SEED, 64'hffff_ffff);
      csr_write(spr_pkg::REG_START_POS, 64'd0);
      gaps_on = 1'b0;
      run_random(12);
      drain();
      csr_write(spr_pkg::REG_LCG_MULT, 64'd0);
      csr_write(spr_pkg::REG_LCG_ADD, 64'd0);
      csr_write(spr_pkg::REG_DITHER_SEED, 64'd0);
      gaps_on = 1'b1;
      run_random(8);
      drain();
   endtask

   task automatic test_receiver_hold();
      csr_write(spr_pkg::REG_STEP, 64'h8000_0000);
      csr_write(spr_pkg::REG_TAP_BLOCKS, 64'd2);
      csr_write(spr_pkg::REG_PHASE_BITS, 64'd3);
      gaps_on = 1'b0;
      long_stall_request = 1'b1;
      run_random(20);
      drain();
   endtask

   task automatic test_random_settings();
      logic [41:0] start;
      int unsigned nt;
      int unsigned pb;
      for (int p = 0; p < 8; p++) begin
         start = {10'($urandom_range(0, 64) - 32), 32'($urandom())};
         nt = $urandom_range(0, 7);
         pb = $urandom_range(0, 7);
         // keep every phase in use inside the filled part of the bank
         while (((1 << ((pb > 5) ? 5 : pb)) + 1) *
                ((nt < 1) ? 8 : (nt > 4) ? 32 : nt * 8) > BANK_FILL)
            pb = pb - 1;
         csr_write(spr_pkg::REG_STEP, {31'd0, $urandom_range(0, 3) == 0,
                              32'($urandom_range(32'h6000_0000, 32'hffff_ffff))});
         csr_write(spr_pkg::REG_TAP_BLOCKS, 64'(nt));
         csr_write(spr_pkg::REG_PHASE_BITS, 64'(pb));
         csr_write(spr_pkg::REG_LCG_MULT, 64'($urandom()));
         csr_write(spr_pkg::REG_LCG_ADD, 64'($urandom()));
         csr_write(spr_pkg::REG_DITHER_SEED, 64'($urandom()));
         csr_write(spr_pkg::REG_START_POS, {{22{start[41]}}, start});
         gaps_on = $urandom_range(0, 3) != 0;
         run_random(5);
         drain();
      end
   endtask

   // receiver: random stalls, plus one long hold-off on request
   always @(negedge clock) begin
      if (long_stall_request) begin
         long_stall_request = 1'b0;
         rsp_hold = 3000;
      end else if (rsp_hold == 0 && gaps_on && $urandom_range(0, 7) == 0) begin
         rsp_hold = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 150)
                                                : $urandom_range(1, 3);
      end
      if (rsp_hold > 0) begin
         rsp_hold = rsp_hold - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      sample_pair_type w;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_words.size() == 0) begin
            $display("%0t: unexpected word left=%h right=%h last=%b",
                     $time, rsp_tdata[15:0], rsp_tdata[31:16], rsp_tlast);
            error_count++;
         end else begin
            w = pending_words.pop_front();
            words_checked++;
            if (rsp_tdata[15:0] !== w.left)
               $display("%0t: left_out expected %h actual %h", $time, w.left,
                        rsp_tdata[15:0]);
            if (rsp_tdata[31:16] !== w.right)
               $display("%0t: right_out expected %h actual %h", $time, w.right,
                        rsp_tdata[31:16]);
            if (rsp_tlast !== w.last)
               $display("%0t: last expected %b actual %b", $time, w.last, rsp_tlast);
            if (rsp_tdata[15:0] !== w.left || rsp_tdata[31:16] !== w.right
                || rsp_tlast !== w.last)
               error_count++;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles = 0;
      else
         idle_cycles = idle_cycles + 1;
      if (idle_cycles >= WATCH_LIMIT) begin
         $display("%0t: no progress for %0d cycles, %0d words outstanding",
                  $time, WATCH_LIMIT, pending_words.size());
         $display("[stereo_polyphase_resampler_top] ERROR");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = 1'b0;
      rsp_tready = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      error_count = 0;
      frames_sent = 0;
      coeffs_sent = 0;
      words_checked = 0;
      idle_cycles = 0;
      gaps_on = 1'b0;
      long_stall_request = 1'b0;
      rsp_hold = 0;
      step_q = spr_pkg::RST_STEP;
      tap_blocks_q = spr_pkg::RST_TAP_BLOCKS;
      phase_bits_q = spr_pkg::RST_PHASE_BITS;
      lcg_mult_q = spr_pkg::RST_LCG_MULT;
      lcg_add_q = spr_pkg::RST_LCG_ADD;
      dither_q = spr_pkg::RST_DITHER_SEED;
      position_q = {{22{spr_pkg::RST_START_POS[41]}}, spr_pkg::RST_START_POS};
      frames_q = '0;
      foreach (hist_left[i]) begin
         hist_left[i] = 0;
         hist_right[i] = 0;
      end
      foreach (coeff_bank[i]) coeff_bank[i] = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_bank_fill();
      test_directed();
      test_output_cap();
      test_extreme_positions();
      test_dither_extremes();
      test_receiver_hold();
      test_random_settings();

      $display("Covered %0d frames and %0d coefficient writes, %0d words checked,",
               frames_sent, coeffs_sent, words_checked);
      $display("over register extremes, output cap, stale history and long stalls.");
      if (error_count == 0)
         $display("[stereo_polyphase_resampler_top] OK");
      else
         $display("[stereo_polyphase_resampler_top] ERROR");
      $finish;
   end

endmodule
